/* rtl/core/indexed_min_heap_queue_unit_defines.svh */
// assertion macro used by the checker file of the heap queue
// no dependencies
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

// implication checked on every rising edge, disabled while reset is low
`define IMHQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

/* rtl/core/imhq_pkg.sv */
// shared types and codes of the indexed min-heap queue
// no dependencies
`default_nettype none
package imhq_pkg;
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_ID   = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  localparam int unsigned IdBits   = 11;
  localparam int unsigned PrioBits = 32;
  localparam int unsigned StatBits = 3;
  localparam logic [IdBits-1:0] CapReset = 11'd1024;
endpackage
`default_nettype wire

/* rtl/core/imhq_ram.sv */
// generic single-port-write, single-read synchronous ram
// no dependencies
`default_nettype none
module imhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/imhq_ctrl.sv */
// sequencer of the heap: command checks, sift-up and sift-down walks
// depends on imhq_pkg and two imhq_ram instances in the top level
`default_nettype none
module imhq_ctrl #(
  parameter int unsigned MaxElements  = 1024,
  parameter int unsigned PriorityBits = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [imhq_pkg::IdBits-1:0]            cap_i,
  input  wire logic                                   in_valid,
  output      logic                                   in_stall,
  input  wire logic [1:0]                             cmd_i,
  input  wire logic [imhq_pkg::IdBits-1:0]            id_i,
  input  wire logic [imhq_pkg::PrioBits-1:0]          prio_i,
  output      logic                                   out_valid,
  input  wire logic                                   out_stall,
  output      logic [imhq_pkg::StatBits-1:0]          status_o,
  output      logic [imhq_pkg::IdBits-1:0]            top_id_o,
  output      logic [imhq_pkg::PrioBits-1:0]          top_prio_o,
  output      logic [imhq_pkg::IdBits-1:0]            count_o,
  output      logic                                   busy_o,
  output      logic                                   found_o,
  output      logic [imhq_pkg::PrioBits-1:0]          elem_prio_o,
  // heap slot memory
  output      logic                                   hp_we_o,
  output      logic [$clog2(MaxElements+1)-1:0]       hp_waddr_o,
  output      logic [$clog2(MaxElements+1)+PriorityBits-1:0] hp_wdata_o,
  output      logic [$clog2(MaxElements+1)-1:0]       hp_raddr_o,
  input  wire logic [$clog2(MaxElements+1)+PriorityBits-1:0] hp_rdata_i,
  // position map memory
  output      logic                                   pm_we_o,
  output      logic [$clog2(MaxElements+1)-1:0]       pm_waddr_o,
  output      logic [$clog2(MaxElements+1)-1:0]       pm_wdata_o,
  output      logic [$clog2(MaxElements+1)-1:0]       pm_raddr_o,
  input  wire logic [$clog2(MaxElements+1)-1:0]       pm_rdata_i
);
  import imhq_pkg::*;

  localparam int unsigned AW = $clog2(MaxElements + 1);
  localparam int unsigned PW = PriorityBits;
  localparam int unsigned DW = AW + PW;
  localparam logic [AW-1:0] MaxCnt = AW'(MaxElements);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_CLR   = 14'h0002,
    S_LOOK  = 14'h0004,
    S_CHECK = 14'h0008,
    S_UPRD  = 14'h0010,
    S_UPCMP = 14'h0020,
    S_DNRDL = 14'h0040,
    S_DNRDR = 14'h0080,
    S_DNCMP = 14'h0100,
    S_TOPRD = 14'h0200,
    S_TOPW  = 14'h0400,
    S_QPM   = 14'h0800,
    S_QRD   = 14'h1000,
    S_OUT   = 14'h2000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [1:0]      cmd_q, cmd_d;
  logic [AW-1:0]   id_q, id_d;
  logic [PW-1:0]   key_q, key_d;
  logic [StatBits-1:0] st_q, st_d;
  logic [AW-1:0]   pos_q, pos_d;     // slot of the moving entry
  logic [AW-1:0]   mid_q, mid_d;     // id of the moving entry
  logic [DW-1:0]   lft_q, lft_d;     // left child contents
  logic [DW-1:0]   tmp_q, tmp_d;
  logic [AW-1:0]   top_id_q, top_id_d;
  logic [PW-1:0]   top_k_q, top_k_d;
  logic            fnd_q, fnd_d;
  logic [PW-1:0]   ek_q, ek_d;
  logic            ov_q, ov_d;

  logic [AW-1:0] cap_eff;
  logic          id_ok;
  logic [AW-1:0] rd_id;
  logic [PW-1:0] rd_key;
  logic [AW:0]   lc, rc;

  assign cap_eff = (32'(cap_i) > MaxElements) ? MaxCnt : AW'(cap_i);
  assign id_ok   = (id_q != '0) && (id_q <= cap_eff);
  assign rd_id   = hp_rdata_i[DW-1:PW];
  assign rd_key  = hp_rdata_i[PW-1:0];
  assign lc      = {pos_q, 1'b0};
  assign rc      = {pos_q, 1'b1};

  function automatic logic lt(input logic [PW-1:0] a, input logic [PW-1:0] b);
    lt = $signed(a) < $signed(b);
  endfunction

  // a waiting result holds off the next transaction
  assign in_stall  = (state_q != S_IDLE) || ov_q;
  assign out_valid = ov_q;
  assign busy_o    = (state_q != S_IDLE);
  assign status_o  = st_q;
  assign top_id_o  = IdBits'(top_id_q);
  assign top_prio_o = 32'($signed(top_k_q));
  assign count_o   = IdBits'(cnt_q);
  assign found_o   = fnd_q;
  assign elem_prio_o = 32'($signed(ek_q));

  always_comb begin
    state_d = state_q; clr_d = clr_q; cnt_d = cnt_q; cmd_d = cmd_q; id_d = id_q;
    key_d = key_q; st_d = st_q; pos_d = pos_q; mid_d = mid_q; lft_d = lft_q;
    tmp_d = tmp_q; top_id_d = top_id_q; top_k_d = top_k_q; fnd_d = fnd_q;
    ek_d = ek_q; ov_d = ov_q;
    hp_we_o = 1'b0; hp_waddr_o = pos_q; hp_wdata_o = {mid_q, key_q};
    hp_raddr_o = pos_q; pm_we_o = 1'b0; pm_waddr_o = mid_q; pm_wdata_o = pos_q;
    pm_raddr_o = id_q;
    if (ov_q && !out_stall) ov_d = 1'b0;
    unique case (state_q)
      S_CLR: begin
        pm_we_o = 1'b1; pm_waddr_o = clr_q; pm_wdata_o = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == MaxCnt) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !ov_q) begin
          cmd_d = cmd_i;
          id_d  = (32'(id_i) > MaxElements) ? '0 : AW'(id_i);
          key_d = PW'($signed(prio_i));
          pm_raddr_o = (32'(id_i) > MaxElements) ? '0 : AW'(id_i);
          state_d = S_LOOK;
        end
      end
      S_LOOK: state_d = S_CHECK; // position map read under way
      S_CHECK: begin
        // pm_rdata_i holds slot of id_q
        tmp_d[AW-1:0] = pm_rdata_i;
        st_d = ST_OK;
        state_d = S_QPM;
        unique case (cmd_e'(cmd_q))
          CMD_INSERT: begin
            if (!id_ok) st_d = ST_BAD_ID;
            else if (pm_rdata_i != '0 && pm_rdata_i <= cnt_q) st_d = ST_PRESENT;
            else if (cnt_q >= cap_eff) st_d = ST_FULL;
            else begin
              cnt_d = cnt_q + 1'b1;
              pos_d = cnt_q + 1'b1; mid_d = id_q;
              state_d = S_UPRD;
            end
          end
          CMD_REMOVE: begin
            if (cnt_q == '0) st_d = ST_EMPTY;
            else begin
              pos_d = cnt_q; state_d = S_TOPRD;
            end
          end
          CMD_UPDATE: begin
            if (!id_ok) st_d = ST_BAD_ID;
            else if (!(pm_rdata_i != '0 && pm_rdata_i <= cnt_q)) st_d = ST_ABSENT;
            else begin
              pos_d = pm_rdata_i; mid_d = id_q;
              state_d = S_UPRD;
            end
          end
          default: begin
            if (!id_ok) st_d = ST_BAD_ID;
            else if (!(pm_rdata_i != '0 && pm_rdata_i <= cnt_q)) st_d = ST_ABSENT;
          end
        endcase
      end
      S_UPRD: begin
        if (cmd_q == CMD_UPDATE) begin
          // old key at the slot decides the direction
          hp_raddr_o = pos_q;
          state_d = S_UPCMP;
        end else if (pos_q == AW'(1)) begin
          hp_we_o = 1'b1; pm_we_o = 1'b1;
          state_d = S_QPM;
        end else begin
          hp_raddr_o = pos_q >> 1;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (cmd_q == CMD_UPDATE) begin
          // rdata is old entry at pos; decide direction
          cmd_d = lt(key_q, rd_key) ? CMD_INSERT : CMD_REMOVE;
          state_d = lt(key_q, rd_key) ? S_UPRD : S_DNRDL;
          if (!lt(key_q, rd_key)) hp_raddr_o = lc[AW-1:0];
        end else if (lt(key_q, rd_key)) begin
          // move parent down into pos
          hp_we_o = 1'b1; hp_wdata_o = hp_rdata_i;
          pm_we_o = 1'b1; pm_waddr_o = rd_id; pm_wdata_o = pos_q;
          pos_d = pos_q >> 1;
          state_d = S_UPRD;
        end else begin
          hp_we_o = 1'b1; pm_we_o = 1'b1;
          state_d = S_QPM;
        end
      end
      S_TOPRD: begin
        // read last entry; S_TOPW clears the map of the top
        hp_raddr_o = cnt_q;
        state_d = S_TOPW;
        tmp_d = '0;
      end
      S_TOPW: begin
        if (tmp_q[0] == 1'b0) begin
          // first pass: last entry captured, now read top
          mid_d = rd_id; key_d = rd_key;
          hp_raddr_o = AW'(1);
          tmp_d[0] = 1'b1;
        end else begin
          pm_we_o = 1'b1; pm_waddr_o = rd_id; pm_wdata_o = '0;
          cnt_d = cnt_q - 1'b1;
          pos_d = AW'(1);
          if (cnt_q == AW'(1)) state_d = S_QPM;
          else begin
            hp_raddr_o = AW'(2);
            state_d = S_DNRDL;
          end
        end
      end
      S_DNRDL: begin
        // left child is in, issue right; with no left child the entry settles here
        lft_d = hp_rdata_i;
        if (lc > (AW+1)'(cnt_q)) begin
          hp_we_o = 1'b1; pm_we_o = 1'b1;
          state_d = S_QPM;
        end else begin
          hp_raddr_o = rc[AW-1:0];
          state_d = S_DNRDR;
        end
      end
      S_DNRDR: begin
        // keep the right child on the read port for the compare
        hp_raddr_o = rc[AW-1:0];
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        logic          use_r;
        logic [DW-1:0] ch;
        logic [AW-1:0] cpos;
        use_r = (rc <= (AW+1)'(cnt_q)) && !lt(lft_q[PW-1:0], rd_key);
        ch    = use_r ? hp_rdata_i : lft_q;
        cpos  = use_r ? rc[AW-1:0] : lc[AW-1:0];
        if (lt(ch[PW-1:0], key_q)) begin
          hp_we_o = 1'b1; hp_wdata_o = ch;
          pm_we_o = 1'b1; pm_waddr_o = ch[DW-1:PW]; pm_wdata_o = pos_q;
          pos_d = cpos;
          hp_raddr_o = AW'({cpos, 1'b0});
          state_d = S_DNRDL;
        end else begin
          hp_we_o = 1'b1; pm_we_o = 1'b1;
          state_d = S_QPM;
        end
      end
      S_QPM: begin
        pm_raddr_o = id_q;
        hp_raddr_o = AW'(1);
        tmp_d = '0;
        state_d = S_QRD;
      end
      S_QRD: begin
        if (tmp_q[0] == 1'b0) begin
          // top entry and map slot are in
          top_id_d = (cnt_q == '0) ? '0 : rd_id;
          top_k_d  = (cnt_q == '0) ? '0 : rd_key;
          tmp_d[AW:1] = pm_rdata_i;
          hp_raddr_o = pm_rdata_i;
          tmp_d[0] = 1'b1;
          fnd_d = id_ok && pm_rdata_i != '0 && pm_rdata_i <= cnt_q;
        end else begin
          ek_d = fnd_q ? rd_key : '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; id_q <= id_d; key_q <= key_d; st_q <= st_d; pos_q <= pos_d;
    mid_q <= mid_d; lft_q <= lft_d; tmp_q <= tmp_d; top_id_q <= top_id_d;
    top_k_q <= top_k_d; fnd_q <= fnd_d; ek_q <= ek_d;
  end
endmodule
`default_nettype wire

/* rtl/core/indexed_min_heap_queue_unit.sv */
// Indexed binary min-heap of element ids with signed fixed-point priorities.
// One command at a time: a transaction is taken while in_stall is low and
// produces one result; in_stall stays high until that result is taken. After
// reset the position map is cleared, entries 0 to MAX_ELEMENTS, with in_stall
// high. A command walks the heap one level at a time, through S_UPRD and
// S_UPCMP when sifting up or S_DNRDL, S_DNRDR and S_DNCMP when sifting down,
// since the heap slot memory has a registered read; on a full 1024-entry
// heap the worst case is an update that sifts down ten levels. The user must
// write capacity only while idle; the block itself does not enforce it.
// depends on imhq_pkg, imhq_ram, imhq_ctrl
`default_nettype none
module indexed_min_heap_queue_unit #(
  parameter int unsigned MAX_ELEMENTS  = 1024,
  parameter int unsigned PRIORITY_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [imhq_pkg::IdBits-1:0]        cfg_data,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [1:0]                         command_i,
  input  wire logic [imhq_pkg::IdBits-1:0]        element_id_i,
  input  wire logic signed [imhq_pkg::PrioBits-1:0] priority_value_i,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [imhq_pkg::StatBits-1:0]      status_o,
  output      logic [imhq_pkg::IdBits-1:0]        top_element_o,
  output      logic signed [imhq_pkg::PrioBits-1:0] top_priority_o,
  output      logic [imhq_pkg::IdBits-1:0]        entry_count_o,
  output      logic                               queue_empty_o,
  output      logic                               element_found_o,
  output      logic signed [imhq_pkg::PrioBits-1:0] element_priority_o
);
  import imhq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DW = AW + PRIORITY_BITS;

  logic [IdBits-1:0] cap_q;
  logic              busy;
  logic              hp_we, pm_we;
  logic [AW-1:0]     hp_wa, hp_ra, pm_wa, pm_ra, pm_wd, pm_rd;
  logic [DW-1:0]     hp_wd, hp_rd;
  logic [PrioBits-1:0] tp, ep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid && cfg_ready) begin
      cap_q <= cfg_data;
    end
  end

  imhq_ram #(.Width(DW), .Depth(2**AW)) u_heap (
    .clk_i, .we_i(hp_we), .waddr_i(hp_wa), .wdata_i(hp_wd),
    .raddr_i(hp_ra), .rdata_o(hp_rd)
  );

  imhq_ram #(.Width(AW), .Depth(2**AW)) u_map (
    .clk_i, .we_i(pm_we), .waddr_i(pm_wa), .wdata_i(pm_wd),
    .raddr_i(pm_ra), .rdata_o(pm_rd)
  );

  imhq_ctrl #(.MaxElements(MAX_ELEMENTS), .PriorityBits(PRIORITY_BITS)) u_ctrl (
    .clk_i, .rst_ni, .cap_i(cap_q),
    .in_valid, .in_stall, .cmd_i(command_i), .id_i(element_id_i),
    .prio_i(priority_value_i),
    .out_valid, .out_stall, .status_o, .top_id_o(top_element_o),
    .top_prio_o(tp), .count_o(entry_count_o), .busy_o(busy),
    .found_o(element_found_o), .elem_prio_o(ep),
    .hp_we_o(hp_we), .hp_waddr_o(hp_wa), .hp_wdata_o(hp_wd),
    .hp_raddr_o(hp_ra), .hp_rdata_i(hp_rd),
    .pm_we_o(pm_we), .pm_waddr_o(pm_wa), .pm_wdata_o(pm_wd),
    .pm_raddr_o(pm_ra), .pm_rdata_i(pm_rd)
  );

  assign top_priority_o     = $signed(tp);
  assign element_priority_o = $signed(ep);
  assign queue_empty_o      = (entry_count_o == '0) && !busy ? 1'b1 :
                              (entry_count_o == '0);
endmodule
`default_nettype wire

/* rtl/core/imhq_checker.sv */
// port-level checks on the heap queue, bound into the top level
// depends on imhq_pkg and indexed_min_heap_queue_unit_defines.svh
`default_nettype none
`include "indexed_min_heap_queue_unit_defines.svh"
module imhq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [imhq_pkg::StatBits-1:0] status_o,
  input wire logic [imhq_pkg::IdBits-1:0]   entry_count_o,
  input wire logic [imhq_pkg::IdBits-1:0]   top_element_o,
  input wire logic                          queue_empty_o
);
  import imhq_pkg::*;

  `IMHQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && out_stall |=> out_valid && $stable(status_o), "result changed while stalled")
  `IMHQ_ASSERT(a_empty, clk_i, rst_ni, out_valid |-> (queue_empty_o == (entry_count_o == '0)), "empty flag mismatch")
  `IMHQ_ASSERT(a_top_zero, clk_i, rst_ni, out_valid && queue_empty_o |-> top_element_o == '0, "top not zero when empty")
  `IMHQ_ASSERT(a_no_take, clk_i, rst_ni, in_valid && !in_stall |=> in_stall, "second transaction taken while busy")
endmodule
bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (.*);
`default_nettype wire

/* test/tb.sv */
// testbench for indexed_min_heap_queue_unit: directed and random commands, scored by a heap model
// depends on imhq_pkg and the heap queue rtl
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import imhq_pkg::*;

  localparam int unsigned MaxElems = 1024;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct {
    status_e              status;
    logic [IdBits-1:0]    top_id;
    logic signed [31:0]   top_key;
    logic [IdBits-1:0]    count;
    logic                 empty;
    logic                 found;
    logic signed [31:0]   found_key;
  } heap_result_t;

  class heap_scoreboard;
    heap_result_t       pending[$];
    logic [IdBits-1:0]  slot_id[MaxElems+1];
    logic signed [31:0] slot_key[MaxElems+1];
    int unsigned        slot_of[MaxElems+1];
    int unsigned        occupied;
    int unsigned        cap_reg;
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        status_hits[6];

    function new();
      foreach (slot_of[i]) slot_of[i] = 0;
      occupied = 0;
      cap_reg = 1024;
      errors = 0;
      checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_capacity(int unsigned v);
      cap_reg = v;
    endfunction

    function int unsigned eff_cap();
      return (cap_reg > MaxElems) ? MaxElems : cap_reg;
    endfunction

    function bit id_ok(int unsigned id);
      return id != 0 && id <= eff_cap();
    endfunction

    function bit id_in(int unsigned id);
      return id_ok(id) && slot_of[id] != 0 && slot_of[id] <= occupied;
    endfunction

    function void swap(int unsigned a, int unsigned b);
      logic [IdBits-1:0]  tid;
      logic signed [31:0] tkey;
      tid = slot_id[a];
      tkey = slot_key[a];
      slot_id[a] = slot_id[b];
      slot_key[a] = slot_key[b];
      slot_id[b] = tid;
      slot_key[b] = tkey;
      slot_of[slot_id[a]] = a;
      slot_of[slot_id[b]] = b;
    endfunction

    function void bubble_up(int unsigned p);
      while (p > 1 && slot_key[p] < slot_key[p/2]) begin
        swap(p, p/2);
        p = p / 2;
      end
    endfunction

    function void bubble_down(int unsigned p);
      int unsigned c;
      forever begin
        c = 2 * p;
        if (c > occupied) return;
        // ties go to the right child
        if (c + 1 <= occupied && slot_key[c+1] <= slot_key[c]) c = c + 1;
        if (!(slot_key[c] < slot_key[p])) return;
        swap(p, c);
        p = c;
      end
    endfunction

    // apply one accepted command and queue the result it should produce
    function void note_command(cmd_e cmd, logic [IdBits-1:0] id, logic signed [31:0] key);
      heap_result_t r;
      int unsigned  p;
      logic signed [31:0] old;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (!id_ok(id)) r.status = ST_BAD_ID;
          else if (id_in(id)) r.status = ST_PRESENT;
          else if (occupied >= eff_cap()) r.status = ST_FULL;
          else begin
            occupied++;
            slot_id[occupied] = id;
            slot_key[occupied] = key;
            slot_of[id] = occupied;
            bubble_up(occupied);
          end
        end
        CMD_REMOVE: begin
          if (occupied == 0) r.status = ST_EMPTY;
          else begin
            slot_of[slot_id[1]] = 0;
            if (occupied > 1) begin
              slot_id[1] = slot_id[occupied];
              slot_key[1] = slot_key[occupied];
              slot_of[slot_id[1]] = 1;
            end
            occupied--;
            if (occupied > 1) bubble_down(1);
          end
        end
        CMD_UPDATE: begin
          if (!id_ok(id)) r.status = ST_BAD_ID;
          else if (!id_in(id)) r.status = ST_ABSENT;
          else begin
            p = slot_of[id];
            old = slot_key[p];
            slot_key[p] = key;
            if (key < old) bubble_up(p);
            else bubble_down(p);
          end
        end
        default: begin
          if (!id_ok(id)) r.status = ST_BAD_ID;
          else if (!id_in(id)) r.status = ST_ABSENT;
        end
      endcase
      r.top_id = (occupied > 0) ? slot_id[1] : '0;
      r.top_key = (occupied > 0) ? slot_key[1] : '0;
      r.count = occupied[IdBits-1:0];
      r.empty = (occupied == 0);
      r.found = id_in(id);
      r.found_key = r.found ? slot_key[slot_of[id]] : '0;
      status_hits[r.status]++;
      pending.push_back(r);
    endfunction

    function void check_result(heap_result_t a);
      heap_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, a.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d act %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.top_id !== e.top_id) begin
        $display("%0t: top_element exp %0d act %0d", $time, e.top_id, a.top_id);
        errors++;
      end
      if (a.top_key !== e.top_key) begin
        $display("%0t: top_priority exp %0d act %0d", $time, e.top_key, a.top_key);
        errors++;
      end
      if (a.count !== e.count) begin
        $display("%0t: entry_count exp %0d act %0d", $time, e.count, a.count);
        errors++;
      end
      if (a.empty !== e.empty) begin
        $display("%0t: queue_empty exp %0d act %0d", $time, e.empty, a.empty);
        errors++;
      end
      if (a.found !== e.found) begin
        $display("%0t: element_found exp %0d act %0d", $time, e.found, a.found);
        errors++;
      end
      if (a.found_key !== e.found_key) begin
        $display("%0t: element_priority exp %0d act %0d", $time, e.found_key, a.found_key);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [IdBits-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                command_i;
  logic [IdBits-1:0]         element_id_i;
  logic signed [PrioBits-1:0] priority_value_i;
  logic                      out_valid;
  logic                      out_stall;
  logic [StatBits-1:0]       status_o;
  logic [IdBits-1:0]         top_element_o;
  logic signed [PrioBits-1:0] top_priority_o;
  logic [IdBits-1:0]         entry_count_o;
  logic                      queue_empty_o;
  logic                      element_found_o;
  logic signed [PrioBits-1:0] element_priority_o;

  heap_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    cycles = 0;
  int unsigned    cap_writes = 0;

  indexed_min_heap_queue_unit dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .command_i, .element_id_i, .priority_value_i,
    .out_valid, .out_stall, .status_o, .top_element_o, .top_priority_o,
    .entry_count_o, .queue_empty_o, .element_found_o, .element_priority_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: sample pre-edge values, then pick the next stall
  always @(posedge clk_i) begin
    heap_result_t a;
    if (rst_ni && out_valid && !out_stall) begin
      a.status = status_e'(status_o);
      a.top_id = top_element_o;
      a.top_key = top_priority_o;
      a.count = entry_count_o;
      a.empty = queue_empty_o;
      a.found = element_found_o;
      a.found_key = element_priority_o;
      sb.check_result(a);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_command(cmd_e cmd, logic [IdBits-1:0] id, logic signed [31:0] key);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= cmd;
    element_id_i <= id;
    priority_value_i <= key;
    do @(posedge clk_i); while (in_stall);
    sb.note_command(cmd, id, key);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [IdBits-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  function automatic logic signed [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return $signed($urandom_range(3)) - 1;   // crowd of ties
    if (r < 36) return 32'sh7fffffff;
    if (r < 42) return 32'sh80000000;
    return $urandom;
  endfunction

  function automatic logic [IdBits-1:0] pick_id(int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 14) return IdBits'($urandom_range(2047));
    return IdBits'($urandom_range(1, (span == 0) ? 1 : span));
  endfunction

  task automatic random_run(int unsigned n, int unsigned span, inout int unsigned done);
    int unsigned r;
    cmd_e        cmd;
    repeat (n) begin
      if (done < 550) begin
        send_idle_pct = 8;
        recv_idle_pct = 70;
      end else if (done < 1100) begin
        send_idle_pct = 70;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (done == 800) wait_drained();
      r = $urandom_range(99);
      cmd = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_REMOVE : (r < 85) ? CMD_UPDATE : CMD_QUERY;
      send_command(cmd, pick_id(span), pick_key());
      done++;
    end
  endtask

  initial begin
    int unsigned done;
    int unsigned caps[8];
    int unsigned spans[8];
    done = 0;
    caps = '{2047, 40, 8, 0, 1, 3, 1024, 200};
    spans = '{60, 40, 8, 6, 2, 3, 1024, 200};
    rst_ni <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    command_i <= CMD_QUERY;
    element_id_i <= '0;
    priority_value_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue, bad ids, extremes, ties, both update directions
    send_command(CMD_QUERY, 11'd5, 0);
    send_command(CMD_REMOVE, 11'd5, 0);
    send_command(CMD_INSERT, 11'd0, 32'sd7);
    send_command(CMD_INSERT, 11'd1024, 32'sh7fffffff);
    send_command(CMD_INSERT, 11'd1, 32'sh80000000);
    send_command(CMD_INSERT, 11'd1, 32'sd3);
    send_command(CMD_INSERT, 11'd2047, 32'sd3);
    send_command(CMD_INSERT, 11'd1025, 32'sd3);
    send_command(CMD_QUERY, 11'd1024, 0);
    send_command(CMD_UPDATE, 11'd1024, -32'sd5);
    send_command(CMD_UPDATE, 11'd1, 32'sh7fffffff);
    send_command(CMD_UPDATE, 11'd3, 32'sd1);
    send_command(CMD_INSERT, 11'd3, -32'sd5);
    send_command(CMD_INSERT, 11'd4, -32'sd5);
    send_command(CMD_INSERT, 11'd5, -32'sd5);
    send_command(CMD_UPDATE, 11'd2047, 32'sd1);
    send_command(CMD_QUERY, 11'd0, 0);
    send_command(CMD_REMOVE, 11'd0, 0);
    send_command(CMD_REMOVE, 11'd4, 0);
    send_command(CMD_REMOVE, 11'd1024, 0);
    send_command(CMD_REMOVE, 11'd1, 0);
    send_command(CMD_REMOVE, 11'd1, 0);
    send_command(CMD_REMOVE, 11'd1, 0);

    random_run(150, 60, done);
    foreach (caps[i]) begin
      // lowering capacity keeps stored ids, so full and stale ids show up
      write_capacity(IdBits'(caps[i]));
      random_run(190, spans[i], done);
    end
    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("ran %0d commands over %0d capacity writes, %0d results checked",
             done + 23, cap_writes, sb.checked);
    $display("status ok %0d full %0d bad id %0d present %0d absent %0d empty %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/imhq_pkg.sv
rtl/core/imhq_ram.sv
rtl/core/imhq_ctrl.sv
rtl/core/indexed_min_heap_queue_unit.sv
rtl/core/imhq_checker.sv
test/tb.sv
